@@ src/csb_pkg.sv @@
// Shared types, constants and address helpers for the cartridge bank mapper.
package csb_pkg;

	localparam int PRG_ADDR_BITS = 19;
	localparam int CHR_ADDR_BITS = 18;
	localparam int MEM_ADDR_W    = 19;
	localparam int CNT_W         = 6;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [CNT_W-1:0] PRG_COUNT_RESET = 6'd32;
	localparam logic [CNT_W-1:0] CHR_COUNT_RESET = 6'd0;

	// Register index, taken from paddr[2].
	localparam logic REG_PRG_COUNT = 1'b0;
	localparam logic REG_CHR_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_CPU_WRITE = 2'd0,
		OP_CPU_READ  = 2'd1,
		OP_PPU_READ  = 2'd2,
		OP_IRQ_TICK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		TGT_NONE      = 3'd0,
		TGT_PRG_ROM   = 3'd1,
		TGT_RAM_READ  = 3'd2,
		TGT_RAM_WRITE = 3'd3,
		TGT_CHR_ROM   = 3'd4,
		TGT_CHR_RAM   = 3'd5,
		TGT_OPEN_BUS  = 3'd6
	} tgt_t;

	// Mapper register regions above 0x8000, from address bits 14..13.
	localparam logic [1:0] RGN_BANK = 2'd0;
	localparam logic [1:0] RGN_MIRR = 2'd1;
	localparam logic [1:0] RGN_IRQL = 2'd2;
	localparam logic [1:0] RGN_IRQE = 2'd3;

	// Address bits 15..13 of the program RAM window at 0x6000.
	localparam logic [2:0] RAM_WINDOW = 3'b011;

	typedef struct packed {
		logic [CNT_W-1:0] prg_count;
		logic [CNT_W-1:0] chr_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0][7:0] bank_regs;
		logic [2:0]      bank_select;
		logic            prg_swap_c000;
		logic            chr_invert;
		logic            mirroring;
		logic            ram_enable;
		logic [7:0]      irq_latch;
		logic [7:0]      irq_count;
		logic            irq_reload;
		logic            irq_enable;
		logic            irq_line;
	} map_state_t;

	typedef struct packed {
		tgt_t                  tgt;
		logic [MEM_ADDR_W-1:0] maddr;
		logic [7:0]            wval;
	} xlate_res_t;

	// Program ROM address of an 8 KB bank and offset, wrapped to PRG_ADDR_BITS.
	function automatic logic [MEM_ADDR_W-1:0] prg_addr(input logic [7:0] bank,
		input logic [12:0] off);
		logic [20:0] full;
		full = {bank, off} & 21'((64'd1 << PRG_ADDR_BITS) - 64'd1);
		return full[MEM_ADDR_W-1:0];
	endfunction

	// Pattern ROM address of a 1 KB bank plus an offset below 2 KB.
	function automatic logic [MEM_ADDR_W-1:0] chr_addr(input logic [7:0] bank,
		input logic [10:0] off);
		logic [18:0] full;
		full = ({1'b0, bank, 10'd0} + {8'd0, off})
			& 19'((64'd1 << CHR_ADDR_BITS) - 64'd1);
		return full[MEM_ADDR_W-1:0];
	endfunction

endpackage

@@ src/csb_cfg.sv @@
// Configuration register file behind the APB-style port.
module csb_cfg
	import csb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_count <= PRG_COUNT_RESET;
			cfg_q.chr_count <= CHR_COUNT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_PRG_COUNT: cfg_q.prg_count <= pwdata[CNT_W-1:0];
				REG_CHR_COUNT: cfg_q.chr_count <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PRG_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, cfg_q.prg_count};
			REG_CHR_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, cfg_q.chr_count};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ src/csb_ctrl.sv @@
// Mapper control registers and the scanline interrupt counter.
module csb_ctrl
	import csb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  op_t        op,
	input  logic [15:0] addr,
	input  logic [7:0] data,
	output map_state_t state,
	output map_state_t state_nxt
);

	map_state_t st_q;
	map_state_t nxt;
	logic [7:0] bank_val;
	logic [7:0] cnt_dec;

	always_comb begin
		nxt      = st_q;
		bank_val = data;
		cnt_dec  = st_q.irq_count - 8'd1;
		if (st_q.bank_select <= 3'd1) begin
			bank_val = data & 8'hFE;
		end else if (st_q.bank_select >= 3'd6) begin
			bank_val = data & 8'h3F;
		end
		case (op)
			OP_CPU_WRITE: begin
				if (addr[15]) begin
					case (addr[14:13])
						RGN_BANK: begin
							if (!addr[0]) begin
								nxt.bank_select   = data[2:0];
								nxt.prg_swap_c000 = data[6];
								nxt.chr_invert    = data[7];
							end else begin
								nxt.bank_regs[st_q.bank_select] = bank_val;
							end
						end
						RGN_MIRR: begin
							if (!addr[0]) begin
								nxt.mirroring = data[0];
							end else begin
								nxt.ram_enable = data[7];
							end
						end
						RGN_IRQL: begin
							if (!addr[0]) begin
								nxt.irq_latch = data;
							end else begin
								nxt.irq_reload = 1'b1;
							end
						end
						default: begin
							nxt.irq_enable = addr[0];
							if (!addr[0]) begin
								nxt.irq_line = 1'b0;
							end
						end
					endcase
				end
			end
			OP_IRQ_TICK: begin
				if (!st_q.irq_enable) begin
					nxt.irq_line = 1'b0;
				end
				// A pending reload or an empty counter reloads instead of counting.
				if (st_q.irq_count == 8'd0 || st_q.irq_reload) begin
					nxt.irq_count  = st_q.irq_latch;
					nxt.irq_reload = 1'b0;
				end else begin
					nxt.irq_count = cnt_dec;
					if (cnt_dec == 8'd0 && st_q.irq_enable) begin
						nxt.irq_line = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

	assign state     = st_q;
	assign state_nxt = nxt;

endmodule

@@ src/csb_xlate.sv @@
// Address translation: picks the target memory and the address within it.
module csb_xlate
	import csb_pkg::*;
(
	input  op_t         op,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	input  map_state_t  state,
	input  cfg_t        cfg,
	output xlate_res_t  res
);

	logic [CNT_W-1:0] last2;
	logic [CNT_W-1:0] last1;
	logic [7:0]       prg_bank;
	logic [2:0]       slot;
	logic [2:0]       reg_idx;
	logic [10:0]      chr_off;
	logic             in_ram;

	assign last2  = {cfg.prg_count[CNT_W-2:0], 1'b0} - 6'd2;
	assign last1  = {cfg.prg_count[CNT_W-2:0], 1'b0} - 6'd1;
	assign in_ram = (addr[15:13] == RAM_WINDOW);

	always_comb begin
		case (addr[14:13])
			2'd0:    prg_bank = state.prg_swap_c000 ? {2'b00, last2} : state.bank_regs[6];
			2'd1:    prg_bank = state.bank_regs[7];
			2'd2:    prg_bank = state.prg_swap_c000 ? state.bank_regs[6] : {2'b00, last2};
			default: prg_bank = {2'b00, last1};
		endcase
	end

	// Inversion swaps the 2 KB half and the 1 KB half of pattern space.
	always_comb begin
		slot = addr[12:10] ^ {state.chr_invert, 2'b00};
		if (!slot[2]) begin
			reg_idx = {2'b00, slot[1]};
			chr_off = {slot[0], addr[9:0]};
		end else begin
			reg_idx = slot - 3'd2;
			chr_off = {1'b0, addr[9:0]};
		end
	end

	always_comb begin
		res.tgt   = TGT_NONE;
		res.maddr = '0;
		res.wval  = '0;
		case (op)
			OP_CPU_WRITE: begin
				if (in_ram && state.ram_enable) begin
					res.tgt   = TGT_RAM_WRITE;
					res.maddr = {6'd0, addr[12:0]};
					res.wval  = data;
				end
			end
			OP_CPU_READ: begin
				if (in_ram) begin
					if (state.ram_enable) begin
						res.tgt   = TGT_RAM_READ;
						res.maddr = {6'd0, addr[12:0]};
					end else begin
						res.tgt = TGT_OPEN_BUS;
					end
				end else if (addr[15]) begin
					res.tgt   = TGT_PRG_ROM;
					res.maddr = prg_addr(prg_bank, addr[12:0]);
				end
			end
			OP_PPU_READ: begin
				if (addr[15:13] == 3'd0) begin
					if (cfg.chr_count != '0) begin
						res.tgt   = TGT_CHR_ROM;
						res.maddr = chr_addr(state.bank_regs[reg_idx], chr_off);
					end else begin
						res.tgt   = TGT_CHR_RAM;
						res.maddr = {6'd0, addr[12:0]};
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ src/cartridge_bank_switch_irq_unit.sv @@
// A result is registered and valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while results are taken; translation and state update are
// combinational between the input handshake and the result register.
// A single result register decouples the sides; a new beat is taken while it drains.
// Reset: arst_n clears mapper state, the interrupt counter and the result valid;
// the bank counts return to 32 program banks and pattern RAM.
module cartridge_bank_switch_irq_unit
	import csb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            target,
	output logic [MEM_ADDR_W-1:0] mem_address,
	output logic [7:0]            ram_write_value,
	output logic                  irq_asserted,
	output logic                  mirror_horizontal,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	map_state_t state;
	map_state_t state_nxt;
	xlate_res_t res;
	op_t        op;
	logic       accept;

	logic                  out_valid_q;
	tgt_t                  target_q;
	logic [MEM_ADDR_W-1:0] mem_address_q;
	logic [7:0]            ram_write_value_q;
	logic                  irq_q;
	logic                  mirror_q;

	assign op       = op_t'(operation);
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign pready   = 1'b1;

	csb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	csb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.addr      (bus_address),
		.data      (write_value),
		.state     (state),
		.state_nxt (state_nxt)
	);

	csb_xlate u_xlate (
		.op    (op),
		.addr  (bus_address),
		.data  (write_value),
		.state (state),
		.cfg   (cfg),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// The interrupt line and mirroring are reported as they stand after the beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			target_q          <= res.tgt;
			mem_address_q     <= res.maddr;
			ram_write_value_q <= res.wval;
			irq_q             <= state_nxt.irq_line;
			mirror_q          <= state_nxt.mirroring;
		end
	end

	assign out_valid         = out_valid_q;
	assign target            = target_q;
	assign mem_address       = mem_address_q;
	assign ram_write_value   = ram_write_value_q;
	assign irq_asserted      = irq_q;
	assign mirror_horizontal = mirror_q;

endmodule

@@ src/csb_checker.sv @@
// Port-level checks for the bank mapper, bound to the top level.
module csb_checker
	import csb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [2:0]            target,
	input logic [MEM_ADDR_W-1:0] mem_address,
	input logic [7:0]            ram_write_value
);

	// With no result held, the block must be able to take a beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while the result register is empty");

	// A result only appears after an input beat was taken.
	a_valid_from_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted input beat");

	// A stalled result holds its target and address.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mem_address))
		else $error("stalled result changed");

	// Accesses that go nowhere carry a zero address.
	a_none_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_NONE || target == TGT_OPEN_BUS) |-> mem_address == '0)
		else $error("nonzero address with no target");

	// Only a program RAM write carries a data byte.
	a_wval_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_RAM_WRITE |-> ram_write_value == 8'd0)
		else $error("write byte present on a non-write result");

endmodule

bind cartridge_bank_switch_irq_unit csb_checker u_csb_checker (.*);

@@ bench/cartridge_bank_switch_irq_unit_check.sv @@
`timescale 1ns / 100ps
// Checker for the cartridge bank mapper: watches both channels and the register port.
module cartridge_bank_switch_irq_unit_check
	import csb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            target,
	input  logic [MEM_ADDR_W-1:0] mem_address,
	input  logic [7:0]            ram_write_value,
	input  logic                  irq_asserted,
	input  logic                  mirror_horizontal,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_checked
);

	typedef struct packed {
		tgt_t                  tgt;
		logic [MEM_ADDR_W-1:0] maddr;
		logic [7:0]            wval;
		logic                  irq;
		logic                  mirr;
	} mapped_access_t;

	mapped_access_t expected_accesses[$];

	// Our own copy of the bank counts and of the mapper state.
	logic [CNT_W-1:0] prg_banks;
	logic [CNT_W-1:0] chr_banks;
	logic [7:0]       bank_num [8];
	logic [2:0]       bank_sel;
	logic             swap_c000;
	logic             chr_inv;
	logic             horiz;
	logic             ram_on;
	logic [7:0]       scan_latch;
	logic [7:0]       scan_count;
	logic             reload_pend;
	logic             irq_on;
	logic             irq_out;
	int               fail_count;

	function automatic void compare_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result %0d, %s expected 0x%0h, got 0x%0h", $time,
					results_checked, name, exp_v, act_v);
		end
	endfunction

	// Applies one bus beat to the state copy and returns the translation it yields.
	function automatic mapped_access_t translate_access(input op_t op, input logic [15:0] a,
		input logic [7:0] d);
		mapped_access_t r;
		logic [31:0]    bank;
		logic [31:0]    full;
		logic [31:0]    fixed_lo;
		logic [2:0]     slot;
		logic [10:0]    off;
		r = '0;
		r.tgt = TGT_NONE;
		case (op)
			OP_CPU_WRITE: begin
				if (a[15:13] == RAM_WINDOW) begin
					if (ram_on) begin
						r.tgt = TGT_RAM_WRITE;
						r.maddr = MEM_ADDR_W'(a[12:0]);
						r.wval = d;
					end
				end else if (a[15]) begin
					case (a[14:13])
						RGN_BANK: begin
							if (!a[0]) begin
								bank_sel = d[2:0];
								swap_c000 = d[6];
								chr_inv = d[7];
							end else begin
								// The 2 KB pattern banks are even, program banks keep six bits.
								bank_num[bank_sel] = (bank_sel <= 3'd1) ? {d[7:1], 1'b0} :
									(bank_sel >= 3'd6) ? {2'b00, d[5:0]} : d;
							end
						end
						RGN_MIRR: begin
							if (!a[0])
								horiz = d[0];
							else
								ram_on = d[7];
						end
						RGN_IRQL: begin
							if (!a[0])
								scan_latch = d;
							else
								reload_pend = 1'b1;
						end
						default: begin
							irq_on = a[0];
							if (!a[0])
								irq_out = 1'b0;
						end
					endcase
				end
			end
			OP_CPU_READ: begin
				if (a[15:13] == RAM_WINDOW) begin
					r.tgt = ram_on ? TGT_RAM_READ : TGT_OPEN_BUS;
					if (ram_on)
						r.maddr = MEM_ADDR_W'(a[12:0]);
				end else if (a[15]) begin
					// The last two 8 KB banks are fixed; the count may wrap these.
					fixed_lo = 32'd2 * 32'(prg_banks) - 32'd2;
					case (a[14:13])
						2'd0: bank = swap_c000 ? fixed_lo : 32'(bank_num[6]);
						2'd1: bank = 32'(bank_num[7]);
						2'd2: bank = swap_c000 ? 32'(bank_num[6]) : fixed_lo;
						default: bank = fixed_lo + 32'd1;
					endcase
					full = (bank * 32'h2000 + 32'(a[12:0])) & ((32'd1 << PRG_ADDR_BITS) - 32'd1);
					r.tgt = TGT_PRG_ROM;
					r.maddr = full[MEM_ADDR_W-1:0];
				end
			end
			OP_PPU_READ: begin
				if (a < 16'h2000) begin
					if (chr_banks != '0) begin
						slot = chr_inv ? a[12:10] + 3'd4 : a[12:10];
						// The low half holds two 2 KB windows, the high half four 1 KB ones.
						if (!slot[2]) begin
							bank = 32'(bank_num[slot[1]]);
							off = {slot[0], a[9:0]};
						end else begin
							bank = 32'(bank_num[slot - 3'd2]);
							off = {1'b0, a[9:0]};
						end
						full = (bank * 32'h400 + 32'(off)) & ((32'd1 << CHR_ADDR_BITS) - 32'd1);
						r.tgt = TGT_CHR_ROM;
						r.maddr = full[MEM_ADDR_W-1:0];
					end else begin
						r.tgt = TGT_CHR_RAM;
						r.maddr = MEM_ADDR_W'(a);
					end
				end
			end
			OP_IRQ_TICK: begin
				if (!irq_on)
					irq_out = 1'b0;
				if (scan_count == 8'd0 || reload_pend) begin
					scan_count = scan_latch;
					reload_pend = 1'b0;
				end else begin
					scan_count = scan_count - 8'd1;
					if (scan_count == 8'd0 && irq_on)
						irq_out = 1'b1;
				end
			end
			default: ;
		endcase
		r.irq = irq_out;
		r.mirr = horiz;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mapped_access_t want;
		if (!arst_n) begin
			prg_banks = PRG_COUNT_RESET;
			chr_banks = CHR_COUNT_RESET;
			foreach (bank_num[i])
				bank_num[i] = 8'd0;
			bank_sel = 3'd0;
			swap_c000 = 1'b0;
			chr_inv = 1'b0;
			horiz = 1'b0;
			ram_on = 1'b0;
			scan_latch = 8'd0;
			scan_count = 8'd0;
			reload_pend = 1'b0;
			irq_on = 1'b0;
			irq_out = 1'b0;
			expected_accesses.delete();
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_accesses.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat arrived with no access outstanding", $time);
				end else begin
					want = expected_accesses.pop_front();
					compare_field("target", 32'(want.tgt), 32'(target));
					compare_field("mem_address", 32'(want.maddr), 32'(mem_address));
					compare_field("ram_write_value", 32'(want.wval), 32'(ram_write_value));
					compare_field("irq_asserted", 32'(want.irq), 32'(irq_asserted));
					compare_field("mirror_horizontal", 32'(want.mirr), 32'(mirror_horizontal));
					results_checked <= results_checked + 1;
				end
			end
			// Count writes land at the access edge, before any later input beat.
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CHR_COUNT)
					chr_banks = pwdata[CNT_W-1:0];
				else
					prg_banks = pwdata[CNT_W-1:0];
			end
			if (in_valid && in_ready)
				expected_accesses.push_back(translate_access(op_t'(operation), bus_address,
					write_value));
			mismatches <= fail_count;
			outstanding <= expected_accesses.size();
		end
	end

endmodule

@@ bench/cartridge_bank_switch_irq_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the cartridge bank mapper: clock, reset, stimulus and verdict.
module cartridge_bank_switch_irq_unit_test;
	import csb_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	op_t                   operation = OP_CPU_WRITE;
	logic [15:0]           bus_address = '0;
	logic [7:0]            write_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            target;
	logic [MEM_ADDR_W-1:0] mem_address;
	logic [7:0]            ram_write_value;
	logic                  irq_asserted;
	logic                  mirror_horizontal;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int outstanding;
	int results_checked;
	int accesses_sent = 0;
	int settings_used = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cartridge_bank_switch_irq_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.bus_address      (bus_address),
		.write_value      (write_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.target           (target),
		.mem_address      (mem_address),
		.ram_write_value  (ram_write_value),
		.irq_asserted     (irq_asserted),
		.mirror_horizontal(mirror_horizontal),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	cartridge_bank_switch_irq_unit_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.bus_address      (bus_address),
		.write_value      (write_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.target           (target),
		.mem_address      (mem_address),
		.ram_write_value  (ram_write_value),
		.irq_asserted     (irq_asserted),
		.mirror_horizontal(mirror_horizontal),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.results_checked  (results_checked)
	);

	// Result side: random stalls, or a long hold-off counted here when one is requested.
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold = 80;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 27);
			end
		end
	end

	// Offers one beat, idling first at random, and returns at the edge that takes it.
	task automatic send_access(input op_t op, input logic [15:0] a, input logic [7:0] d);
		if (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!steady && $urandom_range(99) < 27);
		end
		in_valid <= 1'b1;
		operation <= op;
		bus_address <= a;
		write_value <= d;
		do @(posedge clk); while (!in_ready);
		accesses_sent++;
	endtask

	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	// Leaves the port selected after the access edge so a second write can follow directly.
	task automatic write_bank_count(input logic idx, input logic [CNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_bank_counts(input logic [CNT_W-1:0] prg, input logic [CNT_W-1:0] chr);
		settle_results();
		write_bank_count(REG_PRG_COUNT, prg);
		write_bank_count(REG_CHR_COUNT, chr);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	task automatic random_accesses(input int count);
		int          stop;
		int          pick;
		int          n;
		logic [15:0] a;
		stop = accesses_sent + count;
		while (accesses_sent < stop) begin
			pick = $urandom_range(99);
			a = 16'($urandom);
			if (pick < 22) begin
				// A select beat and then its data beat, the way banks are normally set.
				send_access(OP_CPU_WRITE, {3'b100, a[12:1], 1'b0}, 8'($urandom));
				send_access(OP_CPU_WRITE, {3'b100, a[12:1], 1'b1}, 8'($urandom));
			end else if (pick < 32) begin
				send_access(OP_CPU_WRITE, {1'b1, a[14:0]}, 8'($urandom));
			end else if (pick < 40) begin
				// Short latches let the counter reach zero often.
				send_access(OP_CPU_WRITE, {3'b110, a[12:1], 1'b0},
					($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6)));
				if ($urandom_range(1))
					send_access(OP_CPU_WRITE, {3'b110, a[12:1], 1'b1}, 8'($urandom));
				send_access(OP_CPU_WRITE, {3'b111, a[12:1], ($urandom_range(99) < 75)},
					8'($urandom));
			end else if (pick < 55) begin
				n = $urandom_range(1, 6);
				repeat (n) send_access(OP_IRQ_TICK, 16'($urandom), 8'($urandom));
			end else if (pick < 65) begin
				send_access($urandom_range(1) ? OP_CPU_READ : OP_CPU_WRITE,
					{RAM_WINDOW, a[12:0]}, 8'($urandom));
			end else if (pick < 80) begin
				if ($urandom_range(3) != 0)
					a[15] = 1'b1;
				send_access(OP_CPU_READ, a, 8'($urandom));
			end else if (pick < 95) begin
				if ($urandom_range(4) != 0)
					a[15:13] = 3'b000;
				send_access(OP_PPU_READ, a, 8'($urandom));
			end else begin
				send_access(op_t'($urandom_range(3)), a, 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset counts: 32 program banks, pattern RAM.
		send_access(OP_CPU_READ, 16'h8000, 8'h00);
		send_access(OP_CPU_READ, 16'hFFFF, 8'h00);
		send_access(OP_CPU_READ, 16'h6000, 8'h00);
		send_access(OP_CPU_WRITE, 16'h7ABC, 8'h5A);
		send_access(OP_CPU_WRITE, 16'hA001, 8'h80);
		send_access(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
		send_access(OP_CPU_READ, 16'h6000, 8'h00);
		send_access(OP_CPU_WRITE, 16'h0000, 8'hFF);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h07);
		send_access(OP_CPU_WRITE, 16'h8001, 8'hFF);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h01);
		send_access(OP_CPU_WRITE, 16'h8001, 8'hFF);
		send_access(OP_CPU_WRITE, 16'h8000, 8'hC6);
		send_access(OP_CPU_WRITE, 16'h8001, 8'hFF);
		send_access(OP_CPU_READ, 16'h8000, 8'h00);
		send_access(OP_CPU_READ, 16'hC000, 8'h00);
		send_access(OP_PPU_READ, 16'h1FFF, 8'h00);
		send_access(OP_PPU_READ, 16'h2000, 8'h00);
		send_access(OP_CPU_WRITE, 16'hA000, 8'h01);
		send_access(OP_CPU_WRITE, 16'hC000, 8'h02);
		send_access(OP_CPU_WRITE, 16'hC001, 8'h00);
		send_access(OP_CPU_WRITE, 16'hE001, 8'h00);
		repeat (4) send_access(OP_IRQ_TICK, 16'h0000, 8'h00);
		send_access(OP_CPU_WRITE, 16'hE000, 8'h00);

		// Smallest program size, where the fixed banks are 0 and 1, and the largest pattern ROM.
		set_bank_counts(6'd1, 6'd32);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h80);
		send_access(OP_CPU_WRITE, 16'h8001, 8'h03);
		send_access(OP_PPU_READ, 16'h1400, 8'h00);
		send_access(OP_PPU_READ, 16'h0C00, 8'h00);
		send_access(OP_CPU_READ, 16'hC000, 8'h00);
		send_access(OP_IRQ_TICK, 16'hFFFF, 8'hFF);
		random_accesses(200);

		// Long output stall halfway through, while beats keep coming.
		set_bank_counts(6'd32, 6'd0);
		random_accesses(100);
		hold_req = 1'b1;
		random_accesses(100);

		steady = 1'b1;
		set_bank_counts(6'd17, 6'd8);
		random_accesses(200);
		steady = 1'b0;

		// The sender pauses here until every result has come back.
		set_bank_counts(6'($urandom_range(1, 32)), 6'($urandom_range(0, 32)));
		random_accesses(100);
		settle_results();
		random_accesses(100);

		set_bank_counts(6'd31, 6'd31);
		random_accesses(200);

		settle_results();
		repeat (8) @(posedge clk);
		$display("Run covered %0d bus beats under %0d bank count settings; %0d results compared.",
			accesses_sent, settings_used + 1, results_checked);
		$display("It included register, RAM, program, pattern and tick beats and a long stall.");
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: results stopped arriving.");
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/csb_pkg.sv
src/csb_cfg.sv
src/csb_ctrl.sv
src/csb_xlate.sv
src/cartridge_bank_switch_irq_unit.sv
src/csb_checker.sv
bench/cartridge_bank_switch_irq_unit_check.sv
bench/cartridge_bank_switch_irq_unit_test.sv
